/* sv/assert_macros.svh */
// assertion macros for the transmit-request frame encoder
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define AP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define AP_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define AP_ASSERT(label, clk, rst_n, prop)
`define AP_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* sv/aptx_pkg.sv */
// shared types, constants and helpers of the transmit-request frame encoder
// no dependencies
package aptx_pkg;

    localparam logic [7:0] START_MARK = 8'h7E;
    localparam logic [7:0] ESC_MARK   = 8'h7D;
    localparam logic [7:0] XON_CHAR   = 8'h11;
    localparam logic [7:0] XOFF_CHAR  = 8'h13;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] API_TX_ID  = 8'h10;
    localparam logic [7:0] CKSUM_BASE = 8'hFF;
    localparam logic [8:0] FRAME_OVERHEAD = 9'd14;
    localparam logic [15:0] SHORT_RESET   = 16'hFFFE;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd4;

    typedef enum logic [3:0] {
        ST_START,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_API,
        ST_FID,
        ST_DEST,
        ST_SHORT_HI,
        ST_SHORT_LO,
        ST_RADIUS,
        ST_OPTIONS,
        ST_PAYLOAD,
        ST_CKSUM
    } t_step;

    typedef struct packed {
        logic [7:0] payload;
        logic       first;
        logic       last;
        logic [7:0] frame_id;
        logic [8:0] flen;
    } t_entry;

    function automatic logic needs_esc(input logic [7:0] b);
        needs_esc = (b == START_MARK) || (b == ESC_MARK) ||
                    (b == XON_CHAR) || (b == XOFF_CHAR);
    endfunction

endpackage

/* sv/aptx_if.sv */
// valid/ready channel interfaces: payload input, wire byte output, config write
// depends on aptx_pkg
interface aptx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    modport source (output valid, output payload_byte, input ready);
    modport sink (input valid, input payload_byte, output ready);
endinterface

interface aptx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_frame;
    modport source (output valid, output out_byte, output last_of_item,
                    output end_of_frame, input ready);
    modport sink (input valid, input out_byte, input last_of_item,
                  input end_of_frame, output ready);
endinterface

interface aptx_cfg_if import aptx_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/aptx_front.sv */
// front end: accepts payload requests, tracks frame position and frame id
// depends on aptx_pkg, aptx_if
module aptx_front import aptx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aptx_in_if.sink    i_req,
    input  logic [7:0] i_len,
    input  logic       i_push_ready,
    output logic       o_push_valid,
    output t_entry     o_push_entry
);
    logic [7:0] r_taken, n_taken;
    logic [7:0] r_frame, n_frame;
    logic [7:0] w_eff_len;
    logic [8:0] w_taken_inc;
    logic [7:0] w_fid_inc;
    logic       w_first;
    logic       w_last;
    logic       w_accept;

    assign i_req.ready  = i_push_ready;
    assign w_accept     = i_req.valid && i_push_ready;
    assign o_push_valid = i_req.valid;

    always_comb begin
        w_eff_len   = (i_len == 8'd0) ? 8'd1 : i_len;
        w_first     = (r_taken == 8'd0);
        w_taken_inc = {1'b0, r_taken} + 9'd1;
        w_last      = (w_taken_inc >= {1'b0, w_eff_len});
        w_fid_inc   = r_frame + 8'd1;
        n_frame     = r_frame;
        if (w_first) begin
            n_frame = (w_fid_inc == 8'd0) ? 8'd1 : w_fid_inc;
        end
        n_taken = w_last ? 8'd0 : w_taken_inc[7:0];
    end

    always_comb begin
        o_push_entry.payload  = i_req.payload_byte;
        o_push_entry.first    = w_first;
        o_push_entry.last     = w_last;
        o_push_entry.frame_id = n_frame;
        o_push_entry.flen     = FRAME_OVERHEAD + {1'b0, w_eff_len};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 8'd0;
            r_frame <= 8'd0;
        end else if (w_accept) begin
            r_taken <= n_taken;
            r_frame <= n_frame;
        end
    end
endmodule

/* sv/aptx_queue.sv */
// short request queue between front end and frame sequencer
// depends on aptx_pkg
module aptx_queue import aptx_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    input  t_entry i_push_entry,
    output logic   o_push_ready,
    output logic   o_pop_valid,
    output t_entry o_pop_entry,
    input  logic   i_pop_ready,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign o_count      = r_count;
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

/* sv/aptx_back.sv */
// frame sequencer: walks header, payload and checksum fields, escapes bytes
// depends on aptx_pkg, aptx_if
module aptx_back import aptx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    input  t_entry      i_pop_entry,
    output logic        o_pop_ready,
    input  logic [63:0] i_dest,
    input  logic [15:0] i_short,
    input  logic [7:0]  i_radius,
    input  logic [7:0]  i_options,
    aptx_out_if.source  o_rsp
);
    t_step      r_step, n_step, w_cur;
    logic       r_busy;
    logic       r_esc;
    logic [2:0] r_dest_idx, n_dest_idx;
    logic [7:0] r_sum;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_eof;

    logic [7:0] w_raw;
    logic       w_summed;
    logic       w_item_done;
    logic       w_can_go;
    logic       w_fire;
    logic       w_esc_first;

    assign w_cur = r_busy ? r_step : (i_pop_entry.first ? ST_START : ST_PAYLOAD);
    assign w_can_go    = !r_valid || o_rsp.ready;
    assign w_fire      = w_can_go && (r_busy || i_pop_valid);
    assign w_esc_first = (w_cur != ST_START) && needs_esc(w_raw) && !r_esc;
    assign o_pop_ready = w_fire && !w_esc_first && w_item_done;

    // next field
    always_comb begin
        n_step      = w_cur;
        n_dest_idx  = r_dest_idx;
        w_item_done = 1'b0;
        unique case (w_cur)
            ST_START:    n_step = ST_LEN_HI;
            ST_LEN_HI:   n_step = ST_LEN_LO;
            ST_LEN_LO:   n_step = ST_API;
            ST_API:      n_step = ST_FID;
            ST_FID: begin
                n_step     = ST_DEST;
                n_dest_idx = 3'd0;
            end
            ST_DEST: begin
                n_dest_idx = r_dest_idx + 3'd1;
                if (r_dest_idx == 3'd7) begin
                    n_step = ST_SHORT_HI;
                end
            end
            ST_SHORT_HI: n_step = ST_SHORT_LO;
            ST_SHORT_LO: n_step = ST_RADIUS;
            ST_RADIUS:   n_step = ST_OPTIONS;
            ST_OPTIONS:  n_step = ST_PAYLOAD;
            ST_PAYLOAD: begin
                if (i_pop_entry.last) begin
                    n_step = ST_CKSUM;
                end else begin
                    w_item_done = 1'b1;
                end
            end
            ST_CKSUM:    w_item_done = 1'b1;
            default:     n_step = ST_START;
        endcase
    end

    // field byte
    always_comb begin
        w_raw    = 8'd0;
        w_summed = 1'b1;
        unique case (w_cur)
            ST_START: begin
                w_raw    = START_MARK;
                w_summed = 1'b0;
            end
            ST_LEN_HI: begin
                w_raw    = {7'd0, i_pop_entry.flen[8]};
                w_summed = 1'b0;
            end
            ST_LEN_LO: begin
                w_raw    = i_pop_entry.flen[7:0];
                w_summed = 1'b0;
            end
            ST_API:      w_raw = API_TX_ID;
            ST_FID:      w_raw = i_pop_entry.frame_id;
            ST_DEST:     w_raw = i_dest[{~r_dest_idx, 3'b000} +: 8];
            ST_SHORT_HI: w_raw = i_short[15:8];
            ST_SHORT_LO: w_raw = i_short[7:0];
            ST_RADIUS:   w_raw = i_radius;
            ST_OPTIONS:  w_raw = i_options;
            ST_PAYLOAD:  w_raw = i_pop_entry.payload;
            ST_CKSUM: begin
                w_raw    = CKSUM_BASE - r_sum;
                w_summed = 1'b0;
            end
            default:     w_raw = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_esc      <= 1'b0;
            r_step     <= ST_START;
            r_dest_idx <= 3'd0;
            r_sum      <= 8'd0;
            r_valid    <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
            if (w_fire) begin
                r_valid <= 1'b1;
                if (w_esc_first) begin
                    r_esc  <= 1'b1;
                    r_busy <= 1'b1;
                    r_step <= w_cur;
                end else begin
                    r_esc      <= 1'b0;
                    r_busy     <= !w_item_done;
                    r_step     <= n_step;
                    r_dest_idx <= n_dest_idx;
                    if (w_cur == ST_START) begin
                        r_sum <= 8'd0;
                    end else if (w_summed) begin
                        r_sum <= r_sum + w_raw;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (w_esc_first) begin
                r_byte <= ESC_MARK;
                r_last <= 1'b0;
                r_eof  <= 1'b0;
            end else begin
                r_byte <= r_esc ? (w_raw ^ ESC_XOR) : w_raw;
                r_last <= w_item_done;
                r_eof  <= (w_cur == ST_CKSUM);
            end
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.out_byte     = r_byte;
    assign o_rsp.last_of_item = r_last;
    assign o_rsp.end_of_frame = r_eof;
endmodule

/* sv/api_tx_request_frame_encoder.sv */
// Transmit-request frame encoder, escaped API mode. Each payload request
// yields wire bytes at one byte per cycle, while the output is ready, through
// the single registered output port: a plain payload byte yields one wire byte,
// an escaped one two. The first byte of a frame adds the 17-byte header, whose
// bytes after the start mark may be escaped, and the last adds the checksum.
// A request is taken every cycle the front queue has room, so headers and
// escapes are absorbed while the next payload request waits in the queue. Config
// registers: 0 destination, 1 short address, 2 radius, 3 options,
// 4 payload length; write them only while no frame byte is pending.
`include "assert_macros.svh"
module api_tx_request_frame_encoder import aptx_pkg::*; #(
    parameter int QDEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aptx_in_if.sink    i_req,
    aptx_cfg_if.sink   i_cfg,
    aptx_out_if.source o_rsp
);
    logic [63:0] r_dest;
    logic [15:0] r_short;
    logic [7:0]  r_radius;
    logic [7:0]  r_options;
    logic [7:0]  r_len;

    logic   w_push_valid, w_push_ready;
    t_entry w_push_entry;
    logic   w_pop_valid, w_pop_ready;
    t_entry w_pop_entry;
    logic [$clog2(QDEPTH+1)-1:0] w_q_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest    <= 64'd0;
            r_short   <= SHORT_RESET;
            r_radius  <= 8'd0;
            r_options <= 8'd0;
            r_len     <= 8'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DEST:    r_dest    <= i_cfg.data;
                CFG_SHORT:   r_short   <= i_cfg.data[15:0];
                CFG_RADIUS:  r_radius  <= i_cfg.data[7:0];
                CFG_OPTIONS: r_options <= i_cfg.data[7:0];
                CFG_LENGTH:  r_len     <= i_cfg.data[7:0];
                default:     r_len     <= r_len;
            endcase
        end
    end

    aptx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_len        (r_len),
        .i_push_ready (w_push_ready),
        .o_push_valid (w_push_valid),
        .o_push_entry (w_push_entry)
    );

    aptx_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_entry (w_push_entry),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_entry  (w_pop_entry),
        .i_pop_ready  (w_pop_ready),
        .o_count      (w_q_count)
    );

    aptx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_entry (w_pop_entry),
        .o_pop_ready (w_pop_ready),
        .i_dest      (r_dest),
        .i_short     (r_short),
        .i_radius    (r_radius),
        .i_options   (r_options),
        .o_rsp       (o_rsp)
    );

    // checksum byte always closes its request
    `AP_ASSERT(a_eof_is_last, i_clk, i_rst_n, (o_rsp.valid && o_rsp.end_of_frame) |-> o_rsp.last_of_item)
    // frame id zero is skipped
    `AP_NEVER(a_fid_nonzero, i_clk, i_rst_n, w_push_valid && w_push_entry.first && (w_push_entry.frame_id == 8'd0))
    // queue never overfills
    `AP_NEVER(a_queue_bound, i_clk, i_rst_n, w_q_count > ($clog2(QDEPTH+1))'(QDEPTH))
    // a popped request leaves a byte in the output register
    `AP_ASSERT(a_pop_emits, i_clk, i_rst_n, (w_pop_valid && w_pop_ready) |=> (o_rsp.valid && o_rsp.last_of_item))
endmodule

/* bench/api_tx_request_frame_encoder_test.sv */
// self-checking bench for the transmit-request frame encoder: a scripted
// opening, then randomized register phases and payload bytes under random stalls
// depends on aptx_pkg, aptx_if and api_tx_request_frame_encoder
`timescale 1ns / 1ps
module api_tx_request_frame_encoder_test;
    import aptx_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_PAYLOADS = 280;
    localparam int SCRIPT_ROWS     = 36;
    localparam int WRAP_BUDGET     = 270;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
        logic       eof;
    } t_wire_beat;

    typedef enum logic {
        ROW_WRITE,
        ROW_PAYLOAD
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [63:0]          value;
        logic                 typed;
        logic [5:0]           exp_count;
        logic [7:0]           exp_tail;
    } t_script_row;

    // typed rows carry the byte count and final wire byte of that request
    localparam t_script_row SCRIPT [SCRIPT_ROWS] = '{
        '{ROW_PAYLOAD, CFG_DEST,    64'h00, 1'b1, 6'd19, 8'hF1},
        '{ROW_PAYLOAD, CFG_DEST,    64'hFF, 1'b1, 6'd19, 8'hF1},
        '{ROW_PAYLOAD, CFG_DEST,    64'h7E, 1'b1, 6'd20, 8'h71},
        '{ROW_PAYLOAD, CFG_DEST,    64'h7D, 1'b1, 6'd20, 8'h71},
        '{ROW_PAYLOAD, CFG_DEST,    64'h11, 1'b1, 6'd20, 8'hDC},
        '{ROW_PAYLOAD, CFG_DEST,    64'h13, 1'b1, 6'd20, 8'hD9},
        '{ROW_WRITE,   CFG_LENGTH,  64'h00, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h55, 1'b1, 6'd19, 8'h96},
        '{ROW_WRITE,   CFG_DEST,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd0, 8'h00},
        '{ROW_WRITE,   CFG_SHORT,   64'h0000, 1'b0, 6'd0, 8'h00},
        '{ROW_WRITE,   CFG_RADIUS,  64'hFF, 1'b0, 6'd0,  8'h00},
        '{ROW_WRITE,   CFG_OPTIONS, 64'hFF, 1'b0, 6'd0,  8'h00},
        '{ROW_WRITE,   CFG_LENGTH,  64'hFF, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h00, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h01, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h80, 1'b0, 6'd0,  8'h00},
        '{ROW_WRITE,   CFG_LENGTH,  64'h02, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'hFF, 1'b0, 6'd0,  8'h00},
        '{ROW_WRITE,   CFG_DEST,    64'h7E7D_1113_7E7D_1113, 1'b0, 6'd0, 8'h00},
        '{ROW_WRITE,   CFG_SHORT,   64'h7D13, 1'b0, 6'd0, 8'h00},
        '{ROW_WRITE,   CFG_RADIUS,  64'h11, 1'b0, 6'd0,  8'h00},
        '{ROW_WRITE,   CFG_OPTIONS, 64'h7E, 1'b0, 6'd0,  8'h00},
        '{ROW_WRITE,   CFG_LENGTH,  64'h03, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h7E, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h11, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h20, 1'b0, 6'd0,  8'h00},
        '{ROW_WRITE,   CFG_DEST,    64'h0123_4567_89AB_CDEF, 1'b0, 6'd0, 8'h00},
        '{ROW_WRITE,   CFG_SHORT,   64'hFFFE, 1'b0, 6'd0, 8'h00},
        '{ROW_WRITE,   CFG_RADIUS,  64'h00, 1'b0, 6'd0,  8'h00},
        '{ROW_WRITE,   CFG_OPTIONS, 64'h00, 1'b0, 6'd0,  8'h00},
        '{ROW_WRITE,   CFG_LENGTH,  64'h05, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h13, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h7D, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'hA5, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h5A, 1'b0, 6'd0,  8'h00},
        '{ROW_PAYLOAD, CFG_DEST,    64'h00, 1'b0, 6'd0,  8'h00}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    aptx_in_if  req_ch ();
    aptx_cfg_if cfg_ch ();
    aptx_out_if rsp_ch ();

    api_tx_request_frame_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // encoder shadow state
    logic [63:0] exp_dest    = 64'd0;
    logic [15:0] exp_short   = SHORT_RESET;
    logic [7:0]  exp_radius  = 8'd0;
    logic [7:0]  exp_options = 8'd0;
    logic [7:0]  exp_len     = 8'd1;
    logic [7:0]  frame_id    = 8'd0;
    logic [7:0]  frame_taken = 8'd0;
    logic [7:0]  run_sum     = 8'd0;
    t_wire_beat  wire_expected[$];

    int frames_built   = 0;
    int id_wraps       = 0;
    int payloads_taken = 0;
    int beats_seen     = 0;
    int writes_taken   = 0;
    int err_count      = 0;
    int idle_cycles    = 0;
    int burst_start    = 0;
    int burst_len      = 0;
    logic [7:0] burst_tail = 8'd0;
    bit moved;

    int tx_calm       = 0;
    int rx_calm       = 0;
    bit hold_req      = 1'b0;
    bit quiet         = 1'b1;
    int payloads_sent = 0;

    function void queue_beat(input logic [7:0] b);
        wire_expected.push_back('{b, 1'b0, 1'b0});
    endfunction

    function void queue_escaped(input logic [7:0] b);
        if (b == START_MARK || b == ESC_MARK || b == XON_CHAR || b == XOFF_CHAR) begin
            queue_beat(ESC_MARK);
            queue_beat(b ^ ESC_XOR);
        end else begin
            queue_beat(b);
        end
    endfunction

    function void queue_summed(input logic [7:0] b);
        run_sum = run_sum + b;
        queue_escaped(b);
    endfunction

    function void encode_payload(input logic [7:0] b);
        logic [7:0] eff_len;
        logic [8:0] flen;
        eff_len = (exp_len == 8'd0) ? 8'd1 : exp_len;
        if (frame_taken == 8'd0) begin
            flen = FRAME_OVERHEAD + {1'b0, eff_len};
            frame_id = frame_id + 8'd1;
            if (frame_id == 8'd0) begin
                frame_id = 8'd1;
                id_wraps++;
            end
            frames_built++;
            run_sum = 8'd0;
            queue_beat(START_MARK);
            queue_escaped({7'd0, flen[8]});
            queue_escaped(flen[7:0]);
            queue_summed(API_TX_ID);
            queue_summed(frame_id);
            for (int k = 7; k >= 0; k--) begin
                queue_summed(exp_dest[k*8 +: 8]);
            end
            queue_summed(exp_short[15:8]);
            queue_summed(exp_short[7:0]);
            queue_summed(exp_radius);
            queue_summed(exp_options);
        end
        queue_summed(b);
        frame_taken = frame_taken + 8'd1;
        if (frame_taken >= eff_len) begin
            queue_escaped(CKSUM_BASE - run_sum);
            wire_expected[wire_expected.size()-1].eof = 1'b1;
            frame_taken = 8'd0;
            run_sum = 8'd0;
        end
        wire_expected[wire_expected.size()-1].last = 1'b1;
    endfunction

    function void match_wire_byte();
        t_wire_beat want;
        if (wire_expected.size() == 0) begin
            $error("unexpected wire byte %02h", rsp_ch.out_byte);
            err_count++;
        end else begin
            want = wire_expected.pop_front();
            if (rsp_ch.out_byte !== want.octet) begin
                $error("out_byte: expected %02h, got %02h", want.octet, rsp_ch.out_byte);
                err_count++;
            end
            if (rsp_ch.last_of_item !== want.last) begin
                $error("last_of_item: expected %0b, got %0b", want.last, rsp_ch.last_of_item);
                err_count++;
            end
            if (rsp_ch.end_of_frame !== want.eof) begin
                $error("end_of_frame: expected %0b, got %0b", want.eof, rsp_ch.end_of_frame);
                err_count++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (rsp_ch.valid && rsp_ch.ready) begin
                moved = 1'b1;
                beats_seen++;
                match_wire_byte();
            end
            if (req_ch.valid && req_ch.ready) begin
                moved = 1'b1;
                payloads_taken++;
                burst_start = wire_expected.size();
                encode_payload(req_ch.payload_byte);
                burst_len = wire_expected.size() - burst_start;
                burst_tail = wire_expected[wire_expected.size()-1].octet;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                moved = 1'b1;
                writes_taken++;
                case (cfg_ch.index)
                    CFG_DEST:    exp_dest = cfg_ch.data;
                    CFG_SHORT:   exp_short = cfg_ch.data[15:0];
                    CFG_RADIUS:  exp_radius = cfg_ch.data[7:0];
                    CFG_OPTIONS: exp_options = cfg_ch.data[7:0];
                    CFG_LENGTH:  exp_len = cfg_ch.data[7:0];
                    default: ;
                endcase
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no request moved for %0d cycles", idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // wait before one request or output beat: mostly none, with calm stretches of none
    function automatic int draw_wait(inout int calm);
        int w;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) calm = $urandom_range(8, 40);
        case ($urandom_range(0, 3))
            0: w = $urandom_range(0, 18);
            1: w = $urandom_range(0, 3);
            default: w = 0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] pick_octet();
        logic [7:0] v;
        case ($urandom_range(0, 11))
            0: v = START_MARK;
            1: v = ESC_MARK;
            2: v = XON_CHAR;
            3: v = XOFF_CHAR;
            4: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    function automatic logic [63:0] pick_dest();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = 64'd0;
            1: v = '1;
            default: begin
                for (int k = 0; k < 8; k++) v[k*8 +: 8] = pick_octet();
            end
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_length(input bit force_one);
        logic [7:0] v;
        if (force_one) return 8'd1;
        case ($urandom_range(0, 9))
            0: v = 8'd0;
            7, 8: v = 8'($urandom_range(2, 6));
            9: v = 8'($urandom_range(7, 255));
            default: v = 8'd1;
        endcase
        return v;
    endfunction

    task send_payload(input logic [7:0] b);
        int gap;
        int seen;
        gap = draw_wait(tx_calm);
        if (cfg_ch.valid) cfg_ch.valid <= 1'b0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload_byte <= b;
        seen = payloads_taken;
        do @(negedge i_clk); while (payloads_taken == seen);
        quiet = 1'b0;
        payloads_sent++;
    endtask

    task settle_block();
        if (req_ch.valid) req_ch.valid <= 1'b0;
        if (cfg_ch.valid) cfg_ch.valid <= 1'b0;
        while (wire_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        quiet = 1'b1;
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        int seen;
        if (!quiet) settle_block();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        seen = writes_taken;
        do @(negedge i_clk); while (writes_taken == seen);
    endtask

    initial begin : rsp_side
        int stall;
        int seen;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = draw_wait(rx_calm);
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            seen = beats_seen;
            do @(negedge i_clk); while (beats_seen == seen);
        end
    end

    initial begin : stimulus
        t_script_row row;
        logic [7:0]  len;
        int phase;
        int phase_items;
        int random_start;
        req_ch.valid        = 1'b0;
        req_ch.payload_byte = 8'd0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_DEST;
        cfg_ch.data         = 64'd0;
        i_rst_n             = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            row = SCRIPT[r];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.index, row.value);
            end else begin
                send_payload(row.value[7:0]);
                if (row.typed && (burst_len != int'(row.exp_count) ||
                                  burst_tail != row.exp_tail)) begin
                    $error("script row %0d: expected %0d bytes ending %02h, got %0d ending %02h",
                           r, row.exp_count, row.exp_tail, burst_len, burst_tail);
                    err_count++;
                end
            end
        end

        // random phases; single-byte frames once the id wrap needs the rest of the budget
        phase = 0;
        random_start = payloads_sent;
        while (payloads_sent - random_start < RANDOM_PAYLOADS || id_wraps == 0) begin
            len = pick_length(id_wraps == 0 &&
                              frames_built + RANDOM_PAYLOADS -
                              (payloads_sent - random_start) <= WRAP_BUDGET);
            write_reg(CFG_DEST, pick_dest());
            write_reg(CFG_SHORT, {48'd0, pick_octet(), pick_octet()});
            write_reg(CFG_RADIUS, {56'd0, pick_octet()});
            write_reg(CFG_OPTIONS, {56'd0, pick_octet()});
            write_reg(CFG_LENGTH, {56'd0, len});
            phase_items = $urandom_range(10, 40);
            if (phase == 2) begin
                // output held off while the sender keeps offering back to back
                hold_req = 1'b1;
                tx_calm = phase_items;
            end
            for (int k = 0; k < phase_items; k++) begin
                if (phase == 4 && k == phase_items / 2) settle_block();
                send_payload(pick_octet());
            end
            phase++;
        end

        settle_block();
        $display("sent %0d payload bytes in %0d frames, frame id wrapped %0d time(s)",
                 payloads_taken, frames_built, id_wraps);
        $display("checked %0d wire bytes over %0d register writes and %0d random phases",
                 beats_seen, writes_taken, phase);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
